### src/bms_pkg.sv
package bms_pkg;

  localparam int unsigned SAMPLE_W    = 14;
  localparam int unsigned COUNT_OUT_W = 3;
  localparam int unsigned WEIGHT_W    = 4;
  // old*(10-w) + med*w + 5 peaks at 163835
  localparam int unsigned ACC_W       = 18;
  localparam int unsigned RECIP_W     = 16;
  localparam int unsigned PROD_W      = ACC_W + RECIP_W;
  localparam int unsigned RECIP_SHIFT = 19;

  localparam logic [WEIGHT_W-1:0] FULL_WEIGHT  = 4'd10;
  localparam logic [WEIGHT_W-1:0] RESET_WEIGHT = 4'd3;
  localparam logic [ACC_W-1:0]    ROUND_HALF   = 18'd5;
  // floor(x/10) == (x*52429) >> 19 for every x below 2**18
  localparam logic [RECIP_W-1:0]  RECIP_TEN    = 16'd52429;

  // what one cell hands to its right-hand neighbor
  typedef struct packed {
    logic                occ;
    logic                gt;
    logic [SAMPLE_W-1:0] val;
  } cell_link_t;

endpackage

### src/bms_cell.sv
module bms_cell
  import bms_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                ins_i,
  input  logic                clr_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  cell_link_t          left_i,
  output cell_link_t          right_o
);

  logic                occ_q, occ_d;
  logic [SAMPLE_W-1:0] val_q, val_d;
  logic                gt;
  logic                take;

  assign gt   = occ_q && (val_q > sample_i);
  // either shift right because the new sample lands to our left, or fill the
  // first empty slot
  assign take = ins_i && (gt || (!occ_q && left_i.occ));

  always_comb begin
    occ_d = occ_q;
    val_d = val_q;
    if (clr_i) begin
      occ_d = 1'b0;
    end else if (take) begin
      occ_d = 1'b1;
      val_d = left_i.gt ? left_i.val : sample_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign right_o.occ = occ_q;
  assign right_o.gt  = gt;
  assign right_o.val = val_q;

endmodule

### src/burst_median_smoother_unit.sv
// Channel    Dir  Signals                      Contents (lowest bit first)
// s_axis     in   tvalid/tready/tdata/tuser/   tdata: sample_q4[13:0], zero pad
//                 tlast                        tuser: sample_valid, tlast: burst_last
// m_axis     out  tvalid/tready/tdata/tuser    tdata: smoothed_q4, smoothed_tenths,
//                                              median_q4, accepted_count, pad
//                                              tuser: updated
// cfg        in   cfg_valid_i/cfg_ready_o/     new_weight_tenths[3:0]
//                 cfg_data_i
//
// A beat without tlast is sorted in place by the insertion cell chain; the next beat can follow it without a gap.
// A beat with tlast is followed by median select, multiply-add, reciprocal multiply
// and result load before the next beat is taken.
// Result load waits while the output register holds an untaken beat.
// After reset the sample store is empty, smoothed distance is zero, weight is 3.
module burst_median_smoother_unit
  import bms_pkg::*;
#(
  parameter int unsigned BURST_CAPACITY = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [15:0]         s_axis_tdata,  // sample_q4[13:0], pad
  input  logic                s_axis_tuser,  // sample_valid
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [47:0]         m_axis_tdata,  // smoothed_q4, smoothed_tenths,
                                             // median_q4, accepted_count, pad
  output logic                m_axis_tuser,  // updated
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [WEIGHT_W-1:0] cfg_data_i
);

  localparam int unsigned CNT_W = $clog2(BURST_CAPACITY + 1);
  localparam int unsigned IDX_W = (BURST_CAPACITY > 1) ? $clog2(BURST_CAPACITY) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEDIAN,
    ST_MAC,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e state_q;

  logic [WEIGHT_W-1:0]       weight_q;
  logic [SAMPLE_W-1:0]       smoothed_q;
  logic [SAMPLE_W-1:0]       med_q;
  logic [CNT_W-1:0]          cnt_q;
  logic [ACC_W-1:0]          acc_q;
  logic [PROD_W-1:0]         prod_q;
  logic [47:0]               tdata_q;
  logic                      tuser_q;
  logic                      m_tvalid_q;

  cell_link_t                link [BURST_CAPACITY+1];
  logic [BURST_CAPACITY-1:0] occ_vec;
  logic [SAMPLE_W-1:0]       cell_val [BURST_CAPACITY];
  logic                      in_fire;
  logic                      full;
  logic                      ins;
  logic                      clr;
  logic [CNT_W-1:0]          count;
  logic [IDX_W-1:0]          med_idx;
  logic [WEIGHT_W-1:0]       w_sat;
  logic [ACC_W-1:0]          acc_d;
  logic                      upd;
  logic                      out_free;
  logic [SAMPLE_W-1:0]       quot;
  logic [SAMPLE_W-1:0]       new_s;
  logic [ACC_W-1:0]          times_ten;
  logic [SAMPLE_W-1:0]       tenths;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign full          = occ_vec[BURST_CAPACITY-1];
  assign ins           = in_fire && s_axis_tuser && (s_axis_tdata[SAMPLE_W-1:0] != '0)
                         && !full;
  assign clr           = (state_q == ST_MEDIAN);

  // left end of the chain: always occupied, never above the sample
  assign link[0] = '{occ: 1'b1, gt: 1'b0, val: '0};

  for (genvar i = 0; i < BURST_CAPACITY; i++) begin : g_cell
    bms_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ins_i    (ins),
      .clr_i    (clr),
      .sample_i (s_axis_tdata[SAMPLE_W-1:0]),
      .left_i   (link[i]),
      .right_o  (link[i+1])
    );
    assign occ_vec[i]  = link[i+1].occ;
    assign cell_val[i] = link[i+1].val;
  end

  always_comb begin
    count = '0;
    for (int i = 0; i < BURST_CAPACITY; i++) begin
      count = count + CNT_W'(occ_vec[i]);
    end
  end

  assign med_idx = IDX_W'(count >> 1);
  assign w_sat   = (weight_q > FULL_WEIGHT) ? FULL_WEIGHT : weight_q;
  assign acc_d   = ACC_W'(smoothed_q) * ACC_W'(FULL_WEIGHT - w_sat)
                 + ACC_W'(med_q) * ACC_W'(w_sat) + ROUND_HALF;
  assign upd     = (cnt_q != '0);
  assign quot    = prod_q[RECIP_SHIFT +: SAMPLE_W];

  always_comb begin
    if (!upd) begin
      new_s = smoothed_q;
    end else if (smoothed_q == '0) begin
      new_s = med_q;
    end else begin
      new_s = quot;
    end
  end

  assign times_ten = {1'b0, new_s, 3'b000} + {3'b000, new_s, 1'b0};
  assign tenths    = times_ten[ACC_W-1:4];
  assign out_free  = !m_tvalid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      m_tvalid_q <= 1'b0;
      tdata_q    <= '0;
      tuser_q    <= 1'b0;
      smoothed_q <= '0;
      weight_q   <= RESET_WEIGHT;
    end else begin
      if (cfg_valid_i) begin
        weight_q <= cfg_data_i;
      end
      if ((state_q == ST_OUT) && out_free) begin
        m_tvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_tvalid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire && s_axis_tlast) begin
            state_q <= ST_MEDIAN;
          end
        end
        ST_MEDIAN: state_q <= ST_MAC;
        ST_MAC:    state_q <= ST_DIV;
        ST_DIV:    state_q <= ST_OUT;
        ST_OUT: begin
          if (out_free) begin
            tdata_q    <= {3'b000, COUNT_OUT_W'(cnt_q), med_q, tenths, new_s};
            tuser_q    <= upd;
            smoothed_q <= new_s;
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MEDIAN) begin
      cnt_q <= count;
      med_q <= (count == '0) ? '0 : cell_val[med_idx];
    end
    if (state_q == ST_MAC) begin
      acc_q <= acc_d;
    end
    if (state_q == ST_DIV) begin
      prod_q <= PROD_W'(acc_q) * PROD_W'(RECIP_TEN);
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = tdata_q;
  assign m_axis_tuser  = tuser_q;

  // kept samples always fill the chain from the left
  a_occ_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((occ_vec + 1'b1) & occ_vec) == '0)
    else $error("cell occupancy is not a prefix");

  a_last_starts_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> (state_q == ST_MEDIAN))
    else $error("burst end did not start the median pass");

  a_chain_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MEDIAN) |=> (occ_vec == '0))
    else $error("cell chain not cleared after burst end");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid_q) |-> $past(state_q == ST_OUT))
    else $error("result beat raised outside the load step");

endmodule

### dv/burst_median_smoother_checker.sv
`timescale 1ns / 100ps

module burst_median_smoother_checker
  import bms_pkg::*;
#(
  parameter int unsigned BURST_CAPACITY = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  input  logic [15:0]         s_tdata_i,   // sample_q4[13:0], pad
  input  logic                s_tuser_i,   // sample_valid
  input  logic                s_tlast_i,   // burst_last
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  input  logic [47:0]         m_tdata_i,   // smoothed_q4, smoothed_tenths,
                                           // median_q4, accepted_count, pad
  input  logic                m_tuser_i,   // updated
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [WEIGHT_W-1:0] cfg_data_i,
  output int unsigned         failures_o,
  output int unsigned         pending_o
);

  typedef struct packed {
    logic                   updated;
    logic [COUNT_OUT_W-1:0] accepted_count;
    logic [SAMPLE_W-1:0]    median_q4;
    logic [SAMPLE_W-1:0]    smoothed_tenths;
    logic [SAMPLE_W-1:0]    smoothed_q4;
  } burst_result_t;

  logic [SAMPLE_W-1:0] sorted_store [BURST_CAPACITY];
  int unsigned         kept_n;
  int unsigned         smoothed_dist;
  logic [WEIGHT_W-1:0] weight;
  burst_result_t       burst_results_q [$];

  always @(posedge clk_i or negedge rst_ni) begin
    burst_result_t       want;
    burst_result_t       got;
    logic [SAMPLE_W-1:0] sample;
    int unsigned         pos;
    int unsigned         median;
    int unsigned         w;
    int unsigned         acc;
    if (!rst_ni) begin
      kept_n        = 0;
      smoothed_dist = 0;
      weight        = RESET_WEIGHT;
      burst_results_q.delete();
      failures_o    = 0;
      pending_o     = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got.smoothed_q4     = m_tdata_i[13:0];
        got.smoothed_tenths = m_tdata_i[27:14];
        got.median_q4       = m_tdata_i[41:28];
        got.accepted_count  = m_tdata_i[44:42];
        got.updated         = m_tuser_i;
        if (burst_results_q.size() == 0) begin
          failures_o++;
          if (failures_o <= 10)
            $display("%0t: result beat with nothing expected:", $time,
                     " sm=%0d tenths=%0d med=%0d cnt=%0d upd=%0b",
                     got.smoothed_q4, got.smoothed_tenths, got.median_q4,
                     got.accepted_count, got.updated);
        end else begin
          want = burst_results_q.pop_front();
          if (got !== want) begin
            failures_o++;
            if (failures_o <= 10) begin
              $display("%0t: result mismatch", $time);
              $display("  expected sm=%0d tenths=%0d med=%0d cnt=%0d upd=%0b",
                       want.smoothed_q4, want.smoothed_tenths, want.median_q4,
                       want.accepted_count, want.updated);
              $display("  actual   sm=%0d tenths=%0d med=%0d cnt=%0d upd=%0b",
                       got.smoothed_q4, got.smoothed_tenths, got.median_q4,
                       got.accepted_count, got.updated);
            end
          end
        end
      end

      if (cfg_valid_i && cfg_ready_i)
        weight = cfg_data_i;

      if (s_tvalid_i && s_tready_i) begin
        sample = s_tdata_i[SAMPLE_W-1:0];
        // insertion sort; zero and flagged-bad samples never enter the store
        if (s_tuser_i && sample != 0 && kept_n < BURST_CAPACITY) begin
          pos = kept_n;
          while (pos > 0 && sorted_store[pos-1] > sample) begin
            sorted_store[pos] = sorted_store[pos-1];
            pos--;
          end
          sorted_store[pos] = sample;
          kept_n++;
        end
        if (s_tlast_i) begin
          median      = 0;
          want        = '0;
          if (kept_n > 0) begin
            median = sorted_store[kept_n/2];
            w      = (weight > FULL_WEIGHT) ? FULL_WEIGHT : weight;
            if (smoothed_dist == 0) begin
              smoothed_dist = median;
            end else begin
              acc           = smoothed_dist * (FULL_WEIGHT - w) + median * w + ROUND_HALF;
              smoothed_dist = (acc / 10) & 32'h3FFF;
            end
            want.updated = 1'b1;
          end
          want.smoothed_q4     = smoothed_dist[SAMPLE_W-1:0];
          want.smoothed_tenths = 14'((smoothed_dist * 10) / 16);
          want.median_q4       = median[SAMPLE_W-1:0];
          want.accepted_count  = kept_n[COUNT_OUT_W-1:0];
          burst_results_q.push_back(want);
          kept_n = 0;
        end
      end

      pending_o = burst_results_q.size();
    end
  end

endmodule

### dv/burst_median_smoother_unit_tb.sv
`timescale 1ns / 100ps

module burst_median_smoother_unit_tb
  import bms_pkg::*;
;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned PHASE_ITEMS = 240;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [15:0]         s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                s_axis_tlast = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [47:0]         m_axis_tdata;
  logic                m_axis_tuser;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [WEIGHT_W-1:0] cfg_data = '0;

  int unsigned failures;
  int unsigned pending;
  int unsigned cycles = 0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  bit          sender_steady = 1'b0;

  always #2 clk = ~clk;

  burst_median_smoother_unit i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data)
  );

  burst_median_smoother_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .s_tlast_i   (s_axis_tlast),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .m_tuser_i   (m_axis_tuser),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .failures_o  (failures),
    .pending_o   (pending)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample(logic [SAMPLE_W-1:0] prev);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6)  return '0;
    if (r < 18) return 14'($urandom_range(1, 15));
    if (r < 28) return prev;
    if (r < 38) return 14'(16383 - $urandom_range(0, 15));
    return 14'($urandom_range(0, 16383));
  endfunction

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic send_sample(logic [SAMPLE_W-1:0] sample, logic ok, logic last);
    int unsigned gap;
    gap = sender_steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, sample};
    s_axis_tuser  <= ok;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  // only between bursts, once the block has drained
  task automatic write_weight(logic [WEIGHT_W-1:0] w);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= w;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_bursts(int unsigned n_items);
    int unsigned         sent;
    int unsigned         len;
    int unsigned         valid_pct;
    int unsigned         r;
    logic [SAMPLE_W-1:0] smp;
    logic                ok;
    sent = 0;
    smp  = 14'd1000;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 8)       len = 1;
      else if (r < 85) len = $urandom_range(2, 5);
      else             len = $urandom_range(6, 9);   // overfills the store
      valid_pct = ($urandom_range(0, 9) == 0) ? 25 : 90;
      for (int unsigned i = 0; i < len; i++) begin
        ok  = ($urandom_range(0, 99) < valid_pct);
        smp = pick_sample(smp);
        send_sample(smp, ok, i == len - 1);
        sent++;
      end
    end
  endtask

  // receiver: random stalls plus one long hold-off to back the block up
  initial begin
    int unsigned gap;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(30, 80)) @(negedge clk);
        else repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
  end

  initial begin
    logic [WEIGHT_W-1:0] weights [8];
    weights = '{4'd10, 4'd0, 4'd15, 4'd7, 4'd11, 4'($urandom_range(0, 15)), 4'd1, 4'd4};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part, reset weight
    send_sample(14'd16383, 1'b1, 1'b1);   // first burst loads the smoother
    send_sample(14'd0,     1'b1, 1'b1);   // zero sample rejected, empty burst
    send_sample(14'd100,   1'b0, 1'b1);   // flagged bad, empty burst
    send_sample(14'd5000,  1'b1, 1'b0);   // descending, fills the store
    send_sample(14'd4000,  1'b1, 1'b0);
    send_sample(14'd3000,  1'b1, 1'b0);
    send_sample(14'd2000,  1'b1, 1'b0);
    send_sample(14'd1000,  1'b1, 1'b1);
    send_sample(14'd1,     1'b1, 1'b0);   // overflow: last two dropped
    send_sample(14'd16383, 1'b1, 1'b0);
    send_sample(14'd8,     1'b1, 1'b0);
    send_sample(14'd9,     1'b1, 1'b0);
    send_sample(14'd7,     1'b1, 1'b0);
    send_sample(14'd2,     1'b1, 1'b0);
    send_sample(14'd3,     1'b1, 1'b1);
    send_sample(14'd200,   1'b1, 1'b0);   // even count, upper median
    send_sample(14'd0,     1'b1, 1'b0);
    send_sample(14'd300,   1'b1, 1'b1);
    send_sample(14'd50,    1'b1, 1'b0);
    send_sample(14'd40,    1'b1, 1'b0);
    send_sample(14'd60,    1'b0, 1'b0);
    send_sample(14'd30,    1'b1, 1'b0);
    send_sample(14'd20,    1'b1, 1'b1);

    for (int unsigned p = 0; p < 8; p++) begin
      write_weight(weights[p]);
      sender_steady = (p == 3);
      if (p == 1) hold_req = 1'b1;
      run_bursts(PHASE_ITEMS);
    end
    sender_steady = 1'b0;

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (failures == 0 && pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
